// ===== design/occlusion_priority_scheduler_assert.svh =====
// Assertion helpers used by the scheduler datapath.
// Both sample on clk and are off while rst is high.
`ifndef OCCLUSION_PRIORITY_SCHEDULER_ASSERT_SVH
`define OCCLUSION_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define OPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ops assertion failed");

// Next-cycle implication.
`define OPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ops assertion failed");

`endif

// ===== design/ops_pkg.sv =====
package ops_pkg;

  localparam int MAX_OBJECTS = 1024;
  localparam int IDX_W       = 10;
  localparam int COUNT_W     = 11;
  localparam int PRIO_W      = 2;
  localparam int PHASE_W     = 6;
  localparam int THR_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] MODE_FRAME  = 2'd0;
  localparam logic [1:0] MODE_VISIT  = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 1'b1;

  localparam logic [PRIO_W-1:0] PRIO_TOP    = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_BOTTOM = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [COUNT_W-1:0] object_count;
    logic [IDX_W-1:0]   object_index;
    logic [THR_W-1:0]   sample_count;
  } in_item_t;

  typedef struct packed {
    logic              draw;
    logic              run_probe;
    logic [PRIO_W-1:0] priority_res;
    logic [IDX_W-1:0]  probe_target;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear_we;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_blocked;
  } dp_status_t;

endpackage

// ===== design/ops_ram.sv =====
module ops_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ops_ctrl.sv =====
module ops_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ops_pkg::dp_status_t status,
  output ops_pkg::ctrl_cmd_t  cmd
);

  ops_pkg::state_t state;
  ops_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ops_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ops_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = ops_pkg::ST_IDLE;
      end
      ops_pkg::ST_IDLE: begin
        if (in_valid) state_next = ops_pkg::ST_EXEC;
      end
      ops_pkg::ST_EXEC: begin
        if (!status.out_blocked) state_next = ops_pkg::ST_IDLE;
      end
      default: state_next = ops_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ops_pkg::ST_CLEAR: begin
        cmd.clear_we = 1'b1;
      end
      ops_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ops_pkg::ST_EXEC: begin
        cmd.commit = !status.out_blocked;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/ops_datapath.sv =====
module ops_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ops_pkg::ctrl_cmd_t                   cmd,
  output ops_pkg::dp_status_t                  status,
  input  ops_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ops_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [ops_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ops_pkg::CFG_DATA_W-1:0]       cfg_data
);

  `include "occlusion_priority_scheduler_assert.svh"

  // config
  logic [ops_pkg::THR_W-1:0]   threshold;
  logic [ops_pkg::PHASE_W-1:0] frames_to_skip;

  // scheduler state
  logic [ops_pkg::PHASE_W-1:0] frame_phase;
  logic [ops_pkg::IDX_W-1:0]   target_index;
  logic                        probe_frame;
  logic                        probe_pending;
  logic [ops_pkg::IDX_W-1:0]   clear_addr;
  ops_pkg::in_item_t           item;

  logic [ops_pkg::PHASE_W-1:0] frame_phase_next;
  logic [ops_pkg::IDX_W-1:0]   target_index_next;
  logic                        probe_frame_next;
  logic                        probe_pending_next;
  ops_pkg::out_item_t          result;

  // table port
  logic                        ram_we;
  logic [ops_pkg::IDX_W-1:0]   ram_waddr;
  logic [ops_pkg::PRIO_W-1:0]  ram_wdata;
  logic [ops_pkg::IDX_W-1:0]   ram_raddr;
  logic [ops_pkg::PRIO_W-1:0]  ram_rdata;
  logic                        prio_write;
  logic [ops_pkg::PRIO_W-1:0]  prio_new;

  // frame-start helpers
  logic [ops_pkg::COUNT_W-1:0] count_sat;
  logic [ops_pkg::IDX_W-1:0]   target_dec;
  logic                        target_wrap;
  logic [ops_pkg::PHASE_W-1:0] skip_eff;
  logic [ops_pkg::PHASE_W:0]   phase_inc;
  logic                        is_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      frames_to_skip <= ops_pkg::PHASE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        ops_pkg::CFG_THRESHOLD: threshold      <= cfg_data;
        ops_pkg::CFG_SKIP:      frames_to_skip <= cfg_data[ops_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_we) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign status.clear_last  = (clear_addr == ops_pkg::IDX_W'(ops_pkg::MAX_OBJECTS - 1));
  assign status.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
  end

  // visit reads the visited object, everything else reads the target
  assign ram_raddr = (in_data.mode == ops_pkg::MODE_VISIT) ? in_data.object_index
                                                           : target_index;

  assign ram_we    = cmd.clear_we || prio_write;
  assign ram_waddr = cmd.clear_we ? clear_addr : target_index;
  assign ram_wdata = cmd.clear_we ? ops_pkg::PRIO_TOP : prio_new;

  ops_ram #(
    .WIDTH (ops_pkg::PRIO_W),
    .DEPTH (ops_pkg::MAX_OBJECTS)
  ) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_sat = (item.object_count > ops_pkg::COUNT_W'(ops_pkg::MAX_OBJECTS))
              ? ops_pkg::COUNT_W'(ops_pkg::MAX_OBJECTS) : item.object_count;
    target_dec  = target_index - 1'b1;
    target_wrap = (target_index == '0) || ({1'b0, target_dec} >= count_sat);
    skip_eff    = (frames_to_skip == '0) ? ops_pkg::PHASE_W'(1) : frames_to_skip;
    phase_inc   = {1'b0, frame_phase} + 1'b1;
    is_target   = probe_frame && (item.object_index == target_index);

    // saturating step: visible moves towards top priority
    if (item.sample_count > threshold) begin
      prio_new = (ram_rdata == ops_pkg::PRIO_TOP) ? ram_rdata : ram_rdata - 1'b1;
    end else begin
      prio_new = (ram_rdata == ops_pkg::PRIO_BOTTOM) ? ram_rdata : ram_rdata + 1'b1;
    end

    frame_phase_next   = frame_phase;
    target_index_next  = target_index;
    probe_frame_next   = probe_frame;
    probe_pending_next = probe_pending;
    prio_write         = 1'b0;
    result             = '0;

    case (item.mode)
      ops_pkg::MODE_FRAME: begin
        probe_pending_next = 1'b0;
        probe_frame_next   = (frame_phase == '0);
        if (frame_phase == '0) begin
          if (count_sat == '0) begin
            target_index_next = '0;
            probe_frame_next  = 1'b0;
          end else if (target_wrap) begin
            target_index_next = ops_pkg::IDX_W'(count_sat - 1'b1);
          end else begin
            target_index_next = target_dec;
          end
        end
        frame_phase_next = (phase_inc >= {1'b0, skip_eff}) ? '0
                                                          : phase_inc[ops_pkg::PHASE_W-1:0];
        result.run_probe = probe_frame_next;
      end
      ops_pkg::MODE_VISIT: begin
        if (is_target) probe_pending_next = 1'b1;
        result.run_probe    = is_target;
        result.priority_res = ram_rdata;
        result.draw         = is_target || (ram_rdata == ops_pkg::PRIO_TOP);
      end
      ops_pkg::MODE_REPORT: begin
        probe_pending_next  = 1'b0;
        prio_write          = cmd.commit && probe_pending;
        result.priority_res = probe_pending ? prio_new : ram_rdata;
      end
      default: ;
    endcase
    result.probe_target = target_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase   <= '0;
      target_index  <= '0;
      probe_frame   <= 1'b0;
      probe_pending <= 1'b0;
    end else if (cmd.commit) begin
      frame_phase   <= frame_phase_next;
      target_index  <= target_index_next;
      probe_frame   <= probe_frame_next;
      probe_pending <= probe_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= result;
    end
  end

  `OPS_ASSERT_NOW(a_commit_into_free_slot, cmd.commit, !(out_valid && out_stall))
  `OPS_ASSERT_NEXT(a_commit_gives_beat, cmd.commit, out_valid)
  `OPS_ASSERT_NOW(a_write_only_on_probe, ram_we && !cmd.clear_we,
                  cmd.commit && probe_pending && (item.mode == ops_pkg::MODE_REPORT))
  `OPS_ASSERT_NOW(a_no_accept_while_busy, cmd.accept, !cmd.commit && !cmd.clear_we)

endmodule

// ===== design/occlusion_priority_scheduler.sv =====
// The result beat is registered into the output at the commit in ST_EXEC, which
// follows the accept in ST_IDLE; the beat then waits there until it is taken.
// Items are taken one at a time (accept, then table read settles and commit);
// the commit waits while the output register holds an untaken beat.
// Reset (rst, synchronous) clears control, config and scheduler state, then a pass
// zeroes the priority table, with in_stall high; config writes are still taken.
module occlusion_priority_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ops_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ops_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [ops_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ops_pkg::CFG_DATA_W-1:0] cfg_data
);

  ops_pkg::ctrl_cmd_t  cmd;
  ops_pkg::dp_status_t status;

  ops_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ops_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
